[hw/rtl/tmq_pkg.sv]
// ----------------------------------------------------------------------------
// Timed message queue package
// Shared types, field widths, operation codes and result kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package tmq_pkg;

   // Default sizing of the queue and the time counter.
   localparam int DEPTH_DEF     = 16;
   localparam int TIME_BITS_DEF = 48;

   // Fixed field widths.
   localparam int FUNC_W   = 2;
   localparam int OFFSET_W = 32;
   localparam int ID_W     = 16;
   localparam int KIND_W   = 2;

   // Operation codes carried on the request side.
   localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD      = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RETRIEVE = 2'd2;

   // Result kinds carried on the response side.
   localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd3;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_INS,
      S_CMP,
      S_HEAD,
      S_DRAIN
   } tmq_state_type;

endpackage

`default_nettype wire

[hw/rtl/timed_message_queue_core.sv]
// ----------------------------------------------------------------------------
// Timed message queue core
// Sorted timer event queue of message handles with a running time counter.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_) carries one transaction per operation: a tick
//   advances the time by one (saturating), an add with a nonzero offset
//   inserts a handle due at now plus offset (saturating) or is dropped when
//   the queue is full, a retrieve pops the head at once. The response channel
//   (rsp_) returns one or more transactions per request; rsp_tlast marks the
//   final one. After every request all entries due at or before the current
//   time are delivered in queue order.
//   One request is in work at a time; req_tready is high only while the
//   sequencer is idle. The entries live in a single-port-write memory read
//   one word a cycle, and one compare unit walks them:
//     - the accepting cycle, which also pops the head for a retrieve,
//     - an add compares entries one at a time from the tail back, moving later
//       ones back, plus a write of the new entry when it lands at the head,
//     - each delivery or retrieve pops the head, then refetches any new head,
//     - every request ends with a step that issues its last response.
//   When the receiver stalls, the sequencer waits at the next response with
//   the one before it held in the output register.
//   Reset clears the time, the entry count and all handshake state; the
//   entry memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_message_queue_core #(
   parameter int  DEPTH     = tmq_pkg::DEPTH_DEF,
   parameter int  TIME_BITS = tmq_pkg::TIME_BITS_DEF,
   localparam int CNT_W     = $clog2(DEPTH + 1),
   localparam int RSP_W     = ((tmq_pkg::ID_W + CNT_W + TIME_BITS + 7) / 8) * 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata: offset [31:0], msg_id [47:32]
   input  wire logic [47:0]                     req_tdata,
   // tuser: func [1:0]
   input  wire logic [tmq_pkg::FUNC_W-1:0]      req_tuser,
   // Response channel
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: out_id, queue_count, next_due, zero fill (lowest bit up)
   output logic [RSP_W-1:0]                     rsp_tdata,
   // tuser: kind [1:0]
   output logic [tmq_pkg::KIND_W-1:0]           rsp_tuser,
   output logic                                 rsp_tlast
);

   import tmq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int MEM_W = ID_W + TIME_BITS;
   localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
   localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(DEPTH - 1);

   // Request fields
   logic [FUNC_W-1:0]   req_func;
   logic [OFFSET_W-1:0] req_offset;
   logic [ID_W-1:0]     req_id;

   assign req_func   = req_tuser;
   assign req_offset = req_tdata[OFFSET_W-1:0];
   assign req_id     = req_tdata[OFFSET_W+ID_W-1:OFFSET_W];

   // State and working registers
   tmq_state_type       state_ff, state_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [TIME_BITS-1:0] head_due_ff, head_due_in;
   logic [ID_W-1:0]     head_id_ff, head_id_in;
   logic                pend_ff, pend_in;
   logic [KIND_W-1:0]   pend_kind_ff, pend_kind_in;
   logic [ID_W-1:0]     pend_id_ff, pend_id_in;
   logic [TIME_BITS-1:0] due_ff, due_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [IDX_W-1:0]    scan_ff, scan_in;
   logic [IDX_W-1:0]    wslot_ff, wslot_in;
   logic [CNT_W-1:0]    k_ff, k_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic [TIME_BITS-1:0] rsp_due_ff, rsp_due_in;

   // Entry memory: {handle, due time}
   logic [MEM_W-1:0]    mem [DEPTH];
   logic [MEM_W-1:0]    rd_q_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_wa;
   logic [MEM_W-1:0]    mem_wd;

   // Shared decode
   logic                accept;
   logic                out_free;
   logic                acc_pop;
   logic                drain_more;
   logic                drain_emit;
   logic                drain_pop;
   logic                pop_go;
   logic                ins_ge;
   logic [TIME_BITS:0]  due_sum;
   logic [TIME_BITS-1:0] due_sat;
   logic [IDX_W-1:0]    head_next;
   logic [IDX_W-1:0]    tail_next;
   logic [IDX_W-1:0]    tail_prev;
   logic [IDX_W-1:0]    scan_prev;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign acc_pop  = accept && (req_func == FUNC_RETRIEVE) && (cnt_ff != '0);

   // Drain step: deliver every entry that is due, one pop at a time.
   assign drain_more = (cnt_ff != '0) && (head_due_ff <= now_ff);
   assign drain_emit = (state_ff == S_DRAIN) && out_free && (pend_ff || !drain_more);
   assign drain_pop  = (state_ff == S_DRAIN) && drain_more && (!pend_ff || out_free);
   assign pop_go     = acc_pop || drain_pop;

   // Insert compare: entries due at or after the new one move back.
   assign ins_ge = (rd_q_ff[TIME_BITS-1:0] >= due_ff);

   // Saturating due time
   assign due_sum = {1'b0, now_ff} + (TIME_BITS + 1)'(req_offset);
   assign due_sat = due_sum[TIME_BITS] ? TMAX : due_sum[TIME_BITS-1:0];

   // Ring pointer steps
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;
   assign scan_prev = (scan_ff == '0) ? LAST_IDX : scan_ff - 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (acc_pop) begin
                  state_in = (cnt_ff != CNT_W'(1)) ? S_HEAD : S_DRAIN;
               end else if ((req_func == FUNC_ADD) && (req_offset != '0) &&
                            (cnt_ff != CNT_W'(DEPTH))) begin
                  state_in = S_INS;
               end else begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_INS: begin
            state_in = (k_ff == '0) ? S_DRAIN : S_CMP;
         end
         S_CMP: begin
            state_in = ins_ge ? S_INS : S_DRAIN;
         end
         S_HEAD: begin
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (drain_pop) begin
               state_in = (cnt_ff != CNT_W'(1)) ? S_HEAD : S_DRAIN;
            end else if (drain_emit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath control and register next values
   always_comb begin
      req_tready   = (state_ff == S_IDLE);
      now_in       = now_ff;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      head_due_in  = head_due_ff;
      head_id_in   = head_id_ff;
      pend_in      = pend_ff;
      pend_kind_in = pend_kind_ff;
      pend_id_in   = pend_id_ff;
      due_in       = due_ff;
      id_in        = id_ff;
      scan_in      = scan_ff;
      wslot_in     = wslot_ff;
      k_in         = k_ff;
      rd_addr      = scan_ff;
      mem_we       = 1'b0;
      mem_wa       = wslot_ff;
      mem_wd       = {id_ff, due_ff};
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_due_in   = rsp_due_ff;

      // Start of a request
      if (accept) begin
         id_in = req_id;
         case (req_func)
            FUNC_TICK: begin
               if (now_ff != TMAX) begin
                  now_in = now_ff + 1'b1;
               end
            end
            FUNC_ADD: begin
               if (req_offset != '0) begin
                  if (cnt_ff == CNT_W'(DEPTH)) begin
                     pend_in      = 1'b1;
                     pend_kind_in = KIND_DROPPED;
                     pend_id_in   = req_id;
                  end else begin
                     due_in   = due_sat;
                     scan_in  = tail_prev;
                     wslot_in = tail_ff;
                     k_in     = cnt_ff;
                  end
               end
            end
            FUNC_RETRIEVE: begin
               if (cnt_ff == '0) begin
                  pend_in      = 1'b1;
                  pend_kind_in = KIND_EMPTY;
                  pend_id_in   = '0;
               end
            end
            default: begin
            end
         endcase
      end

      // Insert: write the new entry at the head when no entry is left to compare
      if (state_ff == S_INS && k_ff == '0) begin
         mem_we      = 1'b1;
         head_due_in = due_ff;
         head_id_in  = id_ff;
         cnt_in      = cnt_ff + 1'b1;
         tail_in     = tail_next;
      end

      // Insert: move a later entry back by one slot, or place the new one
      if (state_ff == S_CMP) begin
         mem_we = 1'b1;
         if (ins_ge) begin
            mem_wd   = rd_q_ff;
            wslot_in = scan_ff;
            scan_in  = scan_prev;
            k_in     = k_ff - 1'b1;
         end else begin
            cnt_in  = cnt_ff + 1'b1;
            tail_in = tail_next;
         end
      end

      // Refetch the head after a pop
      if (state_ff == S_HEAD) begin
         head_due_in = rd_q_ff[TIME_BITS-1:0];
         head_id_in  = rd_q_ff[MEM_W-1:TIME_BITS];
      end

      // Issue a response: a pending one, or a status-only one
      if (drain_emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = pend_ff ? pend_kind_ff : KIND_STATUS;
         rsp_id_in    = pend_ff ? pend_id_ff : '0;
         rsp_last_in  = !drain_more;
         rsp_cnt_in   = cnt_ff;
         rsp_due_in   = (cnt_ff != '0) ? head_due_ff : now_ff;
         pend_in      = 1'b0;
      end

      // Pop the head; its response waits until the new head is known
      if (pop_go) begin
         pend_in      = 1'b1;
         pend_kind_in = KIND_DELIVER;
         pend_id_in   = head_id_ff;
         head_in      = head_next;
         cnt_in       = cnt_ff - 1'b1;
         rd_addr      = head_next;
      end
   end

   // Entry memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         now_ff       <= '0;
         cnt_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      head_due_ff  <= head_due_in;
      head_id_ff   <= head_id_in;
      pend_kind_ff <= pend_kind_in;
      pend_id_ff   <= pend_id_in;
      due_ff       <= due_in;
      id_ff        <= id_in;
      scan_ff      <= scan_in;
      wslot_ff     <= wslot_in;
      k_ff         <= k_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_due_ff   <= rsp_due_in;
   end

   // Response ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_W'({rsp_due_ff, rsp_cnt_ff, rsp_id_ff});

   // The entry count never exceeds the queue depth.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // An empty queue has its head and tail pointers together.
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (tail_ff == head_ff))
      else $error("empty queue with split pointers");

   // No response is left pending once the sequencer is idle.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_ff)
      else $error("pending response while idle");

   // A response that is not the last keeps the request in work.
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff != S_IDLE))
      else $error("request finished before its last response");

   // The insert compare only runs with entries left to examine.
   a_cmp_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (k_ff != '0))
      else $error("insert compare with no entry left");

endmodule

`default_nettype wire
